FILE: rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, character codes and helper functions for the HEX record
// encoder: the job handed from the front part to the back part, the bank
// release message, and the character tables.
// ----------------------------------------------------------------------------
package ihex_pkg;

	// Default number of data bytes per record.
	localparam int RECORD_BYTES_DEF = 16;

	// Depth of the job queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Fixed characters of the text.
	localparam logic [6:0] CHAR_COLON   = 7'h3A;
	localparam logic [6:0] CHAR_NEWLINE = 7'h0A;
	localparam logic [6:0] CHAR_ZERO    = 7'h30;
	localparam logic [6:0] CHAR_A       = 7'h41;

	// Record type of a data record.
	localparam logic [7:0] RECORD_TYPE_DATA = 8'h00;

	// End-of-file record ":00000001FF" plus newline.
	localparam int          EOF_LEN  = 12;
	localparam logic [3:0]  EOF_LAST = 4'(EOF_LEN - 1);

	// One record job: the record in one buffer bank, optionally followed by
	// the end-of-file record. A count of zero means no data record.
	typedef struct packed {
		logic        bank;
		logic [7:0]  count;
		logic [15:0] start_addr;
		logic [7:0]  checksum;
		logic        eof;
	} job_t;

	// Back part tells the front part that a buffer bank is free again.
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	// Upper-case hex digit for one nibble.
	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] res;
		if (nib < 4'd10) begin
			res = CHAR_ZERO + {3'b000, nib};
		end else begin
			res = CHAR_A + {3'b000, nib} - 7'd10;
		end
		return res;
	endfunction

	// Characters of the end-of-file record.
	function automatic logic [6:0] eof_char(input logic [3:0] idx);
		logic [6:0] res;
		unique case (idx)
			4'd0:    res = CHAR_COLON;
			4'd8:    res = hex_char(4'd1);
			4'd9:    res = hex_char(4'd15);
			4'd10:   res = hex_char(4'd15);
			4'd11:   res = CHAR_NEWLINE;
			default: res = CHAR_ZERO;
		endcase
		return res;
	endfunction

endpackage

FILE: rtl/ihex_front.sv
// ----------------------------------------------------------------------------
// ihex_front
// Accepts data bytes and end-of-stream commands, tracks the open record,
// writes bytes into a two-bank buffer and hands finished records to the
// job queue.
// ----------------------------------------------------------------------------
module ihex_front import ihex_pkg::*; #(
	parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [23:0]                       s_tdata,   // byte_address, data_byte
	input  logic                              s_tuser,   // command
	output logic                              q_push,
	output job_t                              q_job,
	input  logic                              q_full,
	input  release_t                          rel,
	output logic                              mem_we,
	output logic [$clog2(RECORD_BYTES > 1 ? RECORD_BYTES : 2):0] mem_waddr,
	output logic [7:0]                        mem_wdata
);

	localparam int CNT_W = $clog2(RECORD_BYTES + 1);
	localparam int IDX_W = $clog2(RECORD_BYTES > 1 ? RECORD_BYTES : 2);

	logic             cur_bank_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      start_q;
	logic [7:0]       sum_q;
	logic [1:0]       busy_q;

	logic             is_eof;
	logic [15:0]      addr;
	logic [7:0]       data;
	logic [15:0]      next_addr;
	logic             brk;
	logic             wbank;
	logic [CNT_W-1:0] base_cnt;
	logic [CNT_W-1:0] cnt_inc;
	logic             full;
	logic             push_req;
	logic [7:0]       base_sum;
	logic [7:0]       new_sum;
	logic [15:0]      new_start;
	logic             accept;
	logic [7:0]       old_cnt8;
	logic [1:0]       busy_set;
	logic [1:0]       busy_clr;

	assign is_eof = s_tuser;
	assign addr   = s_tdata[15:0];
	assign data   = s_tdata[23:16];

	// Classify the offered transaction: run break, buffer full, end of stream.
	assign next_addr = start_q + 16'(count_q);
	assign brk       = !is_eof && (count_q != '0) && (next_addr != addr);
	assign wbank     = brk ? ~cur_bank_q : cur_bank_q;
	assign base_cnt  = brk ? '0 : count_q;
	assign cnt_inc   = base_cnt + CNT_W'(1);
	assign full      = !is_eof && (cnt_inc == CNT_W'(RECORD_BYTES));
	assign push_req  = is_eof || brk || full;

	assign base_sum  = (base_cnt == '0) ? (addr[15:8] + addr[7:0]) : sum_q;
	assign new_sum   = base_sum + data;
	assign new_start = (base_cnt == '0) ? addr : start_q;
	assign old_cnt8  = 8'(count_q);

	// Stall while the queue is full or the target bank is still being read.
	assign s_tready = (!push_req || !q_full) && (is_eof || !busy_q[wbank]);
	assign accept   = s_tvalid && s_tready;

	// Job for the queue: the pending record, or the record just filled.
	always_comb begin
		q_job = '0;
		if (brk || is_eof) begin
			q_job.bank       = cur_bank_q;
			q_job.count      = old_cnt8;
			q_job.start_addr = start_q;
			q_job.checksum   = 8'h00 - (sum_q + old_cnt8);
			q_job.eof        = is_eof;
		end else begin
			q_job.bank       = wbank;
			q_job.count      = 8'(RECORD_BYTES);
			q_job.start_addr = new_start;
			q_job.checksum   = 8'h00 - (new_sum + 8'(RECORD_BYTES));
			q_job.eof        = 1'b0;
		end
	end

	assign q_push = accept && push_req;

	// Buffer write for a data byte.
	assign mem_we    = accept && !is_eof;
	assign mem_waddr = {wbank, base_cnt[IDX_W-1:0]};
	assign mem_wdata = data;

	// Bank busy flags: set when a record is queued, cleared when emitted.
	always_comb begin
		busy_set = '0;
		busy_clr = '0;
		if (q_push && (q_job.count != 8'd0)) begin
			busy_set[q_job.bank] = 1'b1;
		end
		if (rel.valid) begin
			busy_clr[rel.bank] = 1'b1;
		end
	end

	// Open record state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_bank_q <= 1'b0;
			count_q    <= '0;
			start_q    <= '0;
			sum_q      <= '0;
			busy_q     <= '0;
		end else begin
			busy_q <= (busy_q & ~busy_clr) | busy_set;
			if (accept) begin
				if (is_eof) begin
					count_q <= '0;
					sum_q   <= '0;
					if (count_q != '0) begin
						cur_bank_q <= ~cur_bank_q;
					end
				end else if (full) begin
					count_q    <= '0;
					sum_q      <= '0;
					start_q    <= new_start;
					cur_bank_q <= ~wbank;
				end else begin
					count_q    <= cnt_inc;
					sum_q      <= new_sum;
					start_q    <= new_start;
					cur_bank_q <= wbank;
				end
			end
		end
	end

endmodule

FILE: rtl/ihex_queue.sv
// ----------------------------------------------------------------------------
// ihex_queue
// Short first-in first-out queue of record jobs between the front part and
// the back part.
// ----------------------------------------------------------------------------
module ihex_queue import ihex_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;

	assign full       = (fill_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_job   = entry_q[rd_ptr_q];

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

FILE: rtl/ihex_back.sv
// ----------------------------------------------------------------------------
// ihex_back
// Holds the two-bank byte buffer and turns each record job into HEX text,
// one character per cycle unless stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module ihex_back import ihex_pkg::*; #(
	parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              mem_we,
	input  logic [$clog2(RECORD_BYTES > 1 ? RECORD_BYTES : 2):0] mem_waddr,
	input  logic [7:0]                        mem_wdata,
	input  logic                              q_valid,
	input  job_t                              q_job,
	output logic                              q_pop,
	output release_t                          rel,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // out_char, zero
	output logic                              m_tlast    // last_char
);

	localparam int CNT_W     = $clog2(RECORD_BYTES + 1);
	localparam int IDX_W     = $clog2(RECORD_BYTES > 1 ? RECORD_BYTES : 2);
	localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

	// Emission phases.
	localparam logic [3:0] P_COLON = 4'd0;
	localparam logic [3:0] P_COUNT = 4'd1;
	localparam logic [3:0] P_ADRH  = 4'd2;
	localparam logic [3:0] P_ADRL  = 4'd3;
	localparam logic [3:0] P_TYPE  = 4'd4;
	localparam logic [3:0] P_DATA  = 4'd5;
	localparam logic [3:0] P_SUM   = 4'd6;
	localparam logic [3:0] P_NL    = 4'd7;
	localparam logic [3:0] P_EOF   = 4'd8;

	logic [7:0]       buf_q [MEM_DEPTH];
	logic [7:0]       rd_data_q;
	logic             active_q;
	job_t             job_q;
	logic [3:0]       phase_q;
	logic             nib_q;
	logic [CNT_W-1:0] idx_q;
	logic [3:0]       eidx_q;
	logic             out_valid_q;
	logic [6:0]       out_char_q;
	logic             out_last_q;

	logic             advance;
	logic             go;
	logic [7:0]       hex_byte;
	logic [3:0]       nib_val;
	logic [6:0]       emit_char;
	logic             emit_last;
	logic             done;
	logic [3:0]       phase_d;
	logic             nib_d;
	logic [CNT_W-1:0] idx_d;
	logic [3:0]       eidx_d;
	logic [IDX_W:0]   rd_addr;

	assign advance = !out_valid_q || m_tready;
	assign go      = active_q && advance;
	assign q_pop   = !active_q && q_valid;

	// Byte selected for the current hex pair.
	always_comb begin
		unique case (phase_q)
			P_COUNT: hex_byte = job_q.count;
			P_ADRH:  hex_byte = job_q.start_addr[15:8];
			P_ADRL:  hex_byte = job_q.start_addr[7:0];
			P_TYPE:  hex_byte = RECORD_TYPE_DATA;
			P_DATA:  hex_byte = rd_data_q;
			P_SUM:   hex_byte = job_q.checksum;
			default: hex_byte = 8'h00;
		endcase
	end

	assign nib_val = nib_q ? hex_byte[3:0] : hex_byte[7:4];

	// Character sequencer.
	always_comb begin
		emit_char = hex_char(nib_val);
		emit_last = 1'b0;
		done      = 1'b0;
		phase_d   = phase_q;
		nib_d     = nib_q;
		idx_d     = idx_q;
		eidx_d    = eidx_q;
		if (go) begin
			unique case (phase_q)
				P_COLON: begin
					emit_char = CHAR_COLON;
					phase_d   = P_COUNT;
					nib_d     = 1'b0;
				end
				P_COUNT, P_ADRH, P_ADRL, P_TYPE: begin
					nib_d = ~nib_q;
					if (nib_q) begin
						phase_d = phase_q + 4'd1;
					end
				end
				P_DATA: begin
					nib_d = ~nib_q;
					if (nib_q) begin
						idx_d = idx_q + CNT_W'(1);
						if (8'(idx_q) + 8'd1 == job_q.count) begin
							phase_d = P_SUM;
						end
					end
				end
				P_SUM: begin
					nib_d = ~nib_q;
					if (nib_q) begin
						phase_d = P_NL;
					end
				end
				P_NL: begin
					emit_char = CHAR_NEWLINE;
					if (job_q.eof) begin
						phase_d = P_EOF;
						eidx_d  = '0;
					end else begin
						emit_last = 1'b1;
						done      = 1'b1;
					end
				end
				P_EOF: begin
					emit_char = eof_char(eidx_q);
					eidx_d    = eidx_q + 4'd1;
					if (eidx_q == EOF_LAST) begin
						emit_last = 1'b1;
						done      = 1'b1;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
	end

	// Free the bank once its record has been written out.
	assign rel.valid = go && done && (job_q.count != 8'd0);
	assign rel.bank  = job_q.bank;

	// Read one entry ahead so the registered data matches the current index.
	assign rd_addr = q_pop ? {q_job.bank, IDX_W'(0)} : {job_q.bank, idx_d[IDX_W-1:0]};

	// Two-bank byte buffer.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			buf_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= buf_q[rd_addr];
	end

	// Job register, sequencer state and output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			phase_q     <= P_COLON;
			nib_q       <= 1'b0;
			idx_q       <= '0;
			eidx_q      <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				phase_q  <= (q_job.count == 8'd0) ? P_EOF : P_COLON;
				nib_q    <= 1'b0;
				idx_q    <= '0;
				eidx_q   <= '0;
			end else begin
				if (go && done) begin
					active_q <= 1'b0;
				end
				phase_q <= phase_d;
				nib_q   <= nib_d;
				idx_q   <= idx_d;
				eidx_q  <= eidx_d;
			end
			if (advance) begin
				out_valid_q <= go;
				out_last_q  <= emit_last;
			end
		end
	end

	// Job payload and output character.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (go) begin
			out_char_q <= emit_char;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;

endmodule

FILE: rtl/intel_hex_record_encoder_core.sv
// A closed record goes through the job queue, the job register and the output stage.
// A record of n bytes is 2n+12 characters, sent at one per cycle while the receiver is ready,
// plus a job-load step, so the single character output port limits the record rate.
// Bytes that open or extend a record are accepted while their buffer bank is free.
// Reset: arst_n clears all control state; buffer contents stay undefined until written.
// ----------------------------------------------------------------------------
// intel_hex_record_encoder_core
// Top level of the HEX record encoder: front part, job queue and back part
// with its two-bank byte buffer.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder_core import ihex_pkg::*; #(
	parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // byte_address [15:0], data_byte [23:16]
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_char [6:0], zero [7]
	output logic        m_tlast    // last_char
);

	localparam int IDX_W = $clog2(RECORD_BYTES > 1 ? RECORD_BYTES : 2);

	logic           q_push;
	job_t           q_push_job;
	logic           q_full;
	logic           q_pop;
	logic           q_valid;
	job_t           q_head;
	release_t       rel;
	logic           mem_we;
	logic [IDX_W:0] mem_waddr;
	logic [7:0]     mem_wdata;

	ihex_front #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_push    (q_push),
		.q_job     (q_push_job),
		.q_full    (q_full),
		.rel       (rel),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	ihex_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_job   (q_head)
	);

	ihex_back #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.q_valid   (q_valid),
		.q_job     (q_head),
		.q_pop     (q_pop),
		.rel       (rel),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: rtl/ihex_checker.sv
// ----------------------------------------------------------------------------
// ihex_checker
// Port-level checks for the HEX record encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ihex_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	// A stalled output transaction holds its character and marker.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	else $error("output transaction changed while stalled");

	// Every run of characters for one input ends in a newline.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == 8'h0A)
	else $error("last character is not a newline");

	// Only colon, hex digits and newline appear in the text.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == 8'h3A) || (m_tdata == 8'h0A) ||
			((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) ||
			((m_tdata >= 8'h41) && (m_tdata <= 8'h46)))
	else $error("character outside the HEX alphabet");

	// A colon never directly follows another colon in the accepted text.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata == 8'h3A |=> !(m_tvalid && m_tdata == 8'h3A))
	else $error("empty record start");

endmodule

bind intel_hex_record_encoder_core ihex_checker u_ihex_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: tb/ihex_text_checker.sv
// ----------------------------------------------------------------------------
// ihex_text_checker
// Watches both stream channels of the HEX record encoder. Each accepted input
// transaction is run through a model of the encoder that queues the expected
// characters. Each accepted output transaction is compared with the oldest
// queued character. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module ihex_text_checker import ihex_pkg::*; #(
	parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // byte_address [15:0], data_byte [23:16]
	input  logic        s_tuser,   // command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // out_char [6:0], zero [7]
	input  logic        m_tlast,   // last_char
	output int          fail_count,
	output int          outstanding
);

	// One expected output character with its end-of-input flag.
	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} text_char_t;

	text_char_t expected_text[$];
	text_char_t step_text[$];

	// Model state: buffered record bytes, fill level, start address, checksum.
	logic [7:0]  rec_bytes [RECORD_BYTES];
	int          rec_fill = 0;
	logic [15:0] rec_addr = '0;
	logic [7:0]  rec_sum  = '0;

	// Upper-case ASCII digit for one nibble.
	function automatic logic [6:0] digit_of(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CHAR_ZERO + {3'b000, nib};
		end
		return CHAR_A + {3'b000, nib} - 7'd10;
	endfunction

	task automatic add_char(input logic [6:0] c);
		text_char_t item;
		item.ch   = c;
		item.last = 1'b0;
		step_text = {step_text, item};
	endtask

	task automatic add_byte(input logic [7:0] b);
		add_char(digit_of(b[7:4]));
		add_char(digit_of(b[3:0]));
	endtask

	// Write the pending data record, if any, and empty the buffer.
	task automatic write_record();
		logic [7:0] total;
		if (rec_fill != 0) begin
			total = rec_sum + 8'(rec_fill);
			add_char(CHAR_COLON);
			add_byte(8'(rec_fill));
			add_byte(rec_addr[15:8]);
			add_byte(rec_addr[7:0]);
			add_byte(RECORD_TYPE_DATA);
			for (int i = 0; i < rec_fill; i++) begin
				add_byte(rec_bytes[i]);
			end
			add_byte(8'h00 - total);
			add_char(CHAR_NEWLINE);
			rec_fill = 0;
			rec_sum  = '0;
		end
	endtask

	// Work out the characters caused by one input transaction.
	task automatic predict_text(input logic cmd, input logic [15:0] addr,
			input logic [7:0] data);
		logic [15:0] next_addr;
		step_text.delete();
		if (cmd) begin
			// End of stream: flush, then the end-of-file record.
			write_record();
			add_char(CHAR_COLON);
			for (int k = 0; k < 10; k++) begin
				add_char(digit_of(k == 7 ? 4'd1 : (k >= 8 ? 4'd15 : 4'd0)));
			end
			add_char(CHAR_NEWLINE);
		end else begin
			// A byte that does not follow the run closes the pending record.
			next_addr = rec_addr + 16'(rec_fill);
			if (rec_fill != 0 && next_addr != addr) begin
				write_record();
			end
			if (rec_fill == 0) begin
				rec_addr = addr;
				rec_sum  = addr[15:8] + addr[7:0];
			end
			if (rec_fill < RECORD_BYTES) begin
				rec_bytes[rec_fill] = data;
				rec_fill++;
			end
			rec_sum = rec_sum + data;
			if (rec_fill >= RECORD_BYTES) begin
				write_record();
			end
		end
		if (step_text.size() > 0) begin
			step_text[step_text.size() - 1].last = 1'b1;
		end
		expected_text = {expected_text, step_text};
	endtask

	task automatic note_failure(input string what, input text_char_t want);
		if (fail_count < 10) begin
			$display("mismatch (%s): expected char %h last %b, got tdata %h tlast %b",
				what, want.ch, want.last, m_tdata, m_tlast);
		end
		fail_count++;
	endtask

	// Predict on input transactions first, then check output transactions.
	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			rec_fill = 0;
			rec_addr = '0;
			rec_sum  = '0;
			expected_text.delete();
			outstanding = 0;
			fail_count  = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_text(s_tuser, s_tdata[15:0], s_tdata[23:16]);
			end
			if (m_tvalid && m_tready) begin
				if (expected_text.size() == 0) begin
					note_failure("unexpected character", '0);
				end else begin
					want = expected_text.pop_front();
					if (m_tdata[6:0] !== want.ch || m_tdata[7] !== 1'b0 ||
							m_tlast !== want.last) begin
						note_failure("wrong character", want);
					end
				end
			end
			outstanding = expected_text.size();
		end
	end

endmodule

FILE: tb/intel_hex_record_encoder_core_tb.sv
// ----------------------------------------------------------------------------
// intel_hex_record_encoder_core_tb
// Drives data bytes and end-of-stream commands into the HEX record encoder
// with random gaps on both sides and reports the verdict of the checker.
// A directed part covers full records, address wrap, run breaks and an empty
// flush; random runs of following addresses make up the rest.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder_core_tb;

	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int ITEMS_PER_SET = 112;
	localparam logic CMD_DATA    = 1'b0;
	localparam logic CMD_EOF     = 1'b1;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // byte_address [15:0], data_byte [23:16]
	logic        s_tuser  = 1'b0; // command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // out_char [6:0], zero [7]
	logic        m_tlast;         // last_char

	int fail_count;
	int outstanding;
	int src_idle_pct  = 25;
	int sink_idle_pct = 74;

	intel_hex_record_encoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	ihex_text_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver stalls at random.
	always @(negedge clk) begin
		m_tready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
	end

	// End the run when no transaction has happened for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Offer one input item, with random idle cycles first, until accepted.
	task automatic offer_item(input logic cmd, input logic [15:0] addr,
			input logic [7:0] data);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {data, addr};
		s_tuser  <= cmd;
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// End of stream with random values in the ignored fields.
	task automatic offer_eof();
		offer_item(CMD_EOF, 16'($urandom), 8'($urandom));
	endtask

	// Hold the sender until every expected character has come out.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
	endtask

	// Mostly runs of following addresses, with stray bytes and flushes mixed in.
	task automatic random_set(input int n_items);
		int          sent;
		int          kind;
		int          run_len;
		logic [15:0] start;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				start   = ($urandom_range(7) == 0) ? 16'hFFF0 + 16'($urandom_range(15))
				                                   : 16'($urandom);
				run_len = ($urandom_range(9) == 0) ? $urandom_range(17, 40)
				                                   : $urandom_range(1, 18);
				for (int j = 0; j < run_len; j++) begin
					offer_item(CMD_DATA, start + 16'(j), 8'($urandom));
				end
				sent += run_len;
				if ($urandom_range(3) == 0) begin
					offer_eof();
					sent++;
				end
			end else if (kind < 92) begin
				offer_item(CMD_DATA, 16'($urandom), 8'($urandom));
				sent++;
			end else begin
				offer_eof();
				sent++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: end of stream with an empty buffer.
		offer_eof();
		// Single byte at the lowest address and value.
		offer_item(CMD_DATA, 16'h0000, 8'h00);
		offer_eof();
		// A full record that wraps from the top address to zero.
		for (int j = 0; j < 16; j++) begin
			offer_item(CMD_DATA, 16'hFFF8 + 16'(j), (j % 2 == 0) ? 8'hFF : 8'(j * 17));
		end
		// A run broken by an address that does not follow on.
		offer_item(CMD_DATA, 16'h1234, 8'h5A);
		offer_item(CMD_DATA, 16'h1235, 8'hA5);
		offer_item(CMD_DATA, 16'hFFFF, 8'hFF);
		offer_eof();

		// Sender idles less than the receiver.
		random_set(ITEMS_PER_SET);
		offer_eof();
		wait_drained();

		// Receiver idles less than the sender.
		src_idle_pct  = 74;
		sink_idle_pct = 25;
		random_set(ITEMS_PER_SET);
		offer_eof();
		wait_drained();

		// No idling on either side.
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		random_set(ITEMS_PER_SET);
		offer_eof();

		// Drain the remaining characters and give the block time to settle.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
